// ===== sv/pfanm_pkg.sv =====
// ============================================================================
// pfanm_pkg
// shared types, widths and command codes of the pseudo-float add/mul unit
// ============================================================================
`default_nettype none

package pfanm_pkg;

  localparam int unsigned FRAC_BITS_DEF = 25;
  localparam int unsigned CMD_W         = 2;
  localparam int unsigned EXP_W         = 16;
  localparam int unsigned FRAC_W        = 32;
  // exact intermediate fraction: a full 32x32 product fits here
  localparam int unsigned WIDE_W        = 64;
  // exponent before normalization: sum of two exponents
  localparam int unsigned MID_EXP_W     = EXP_W + 1;
  // bit length of a wide magnitude: 0 to 64
  localparam int unsigned LEN_W         = $clog2(WIDE_W + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_RSV = 2'd3   // decodes as multiply
  } cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic signed [EXP_W-1:0]  x_exponent;
    logic signed [FRAC_W-1:0] x_fraction;
    logic signed [EXP_W-1:0]  y_exponent;
    logic signed [FRAC_W-1:0] y_fraction;
  } in_word_t;

  // raw result before normalization
  typedef struct packed {
    logic signed [MID_EXP_W-1:0] exponent;
    logic signed [WIDE_W-1:0]    fraction;
  } mid_word_t;

  typedef struct packed {
    logic signed [EXP_W-1:0]  z_exponent;
    logic signed [FRAC_W-1:0] z_fraction;
  } out_word_t;

  // number of bits up to and including the highest set bit
  function automatic logic [LEN_W-1:0] bit_len(input logic [WIDE_W-1:0] v);
    logic [LEN_W-1:0] len;
    len = '0;
    for (int i = 0; i < WIDE_W; i++) begin
      if (v[i]) begin
        len = LEN_W'(i + 1);
      end
    end
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== sv/pfanm_if.sv =====
// ============================================================================
// pfanm interfaces
// valid/ready channels for operand words and result words
// ============================================================================
`default_nettype none

interface pfanm_in_if;
  import pfanm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic signed [EXP_W-1:0]  x_exponent;
  logic signed [FRAC_W-1:0] x_fraction;
  logic signed [EXP_W-1:0]  y_exponent;
  logic signed [FRAC_W-1:0] y_fraction;

  modport source (
    output valid, cmd, x_exponent, x_fraction, y_exponent, y_fraction,
    input  ready
  );
  modport sink (
    input  valid, cmd, x_exponent, x_fraction, y_exponent, y_fraction,
    output ready
  );
endinterface

interface pfanm_out_if;
  import pfanm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [EXP_W-1:0]  z_exponent;
  logic signed [FRAC_W-1:0] z_fraction;

  modport source (
    output valid, z_exponent, z_fraction,
    input  ready
  );
  modport sink (
    input  valid, z_exponent, z_fraction,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/pfanm_arith.sv =====
// ============================================================================
// pfanm_arith
// aligns and adds/subtracts, or multiplies, at full width without wrap
// ============================================================================
`default_nettype none

module pfanm_arith #(
  parameter int unsigned FRAC_BITS = pfanm_pkg::FRAC_BITS_DEF
) (
  input  pfanm_pkg::in_word_t  word_i,
  output pfanm_pkg::mid_word_t word_o
);
  import pfanm_pkg::*;

  localparam int unsigned SUM_W = FRAC_W + 2;
  localparam int unsigned OPD_W = FRAC_W + 1;
  localparam int unsigned SH_W  = $clog2(WIDE_W);
  localparam logic [MID_EXP_W-1:0] SH_MAX = MID_EXP_W'(WIDE_W - 1);

  logic signed [MID_EXP_W-1:0] xe, ye;
  logic signed [OPD_W-1:0]     xf, yf, big_f, small_f, small_sh;
  logic                        x_big, is_mul;
  logic [MID_EXP_W-1:0]        diff;
  logic [SH_W-1:0]             shamt;
  logic signed [SUM_W-1:0]     sum;
  logic signed [WIDE_W-1:0]    prod;

  always_comb begin
    xe = {word_i.x_exponent[EXP_W-1], word_i.x_exponent};
    ye = {word_i.y_exponent[EXP_W-1], word_i.y_exponent};
    xf = {word_i.x_fraction[FRAC_W-1], word_i.x_fraction};
    yf = {word_i.y_fraction[FRAC_W-1], word_i.y_fraction};
    if (word_i.cmd == CMD_SUB) begin
      yf = -yf;
    end

    x_big   = xe > ye;
    diff    = x_big ? MID_EXP_W'(xe - ye) : MID_EXP_W'(ye - xe);
    shamt   = (diff > SH_MAX) ? SH_W'(SH_MAX) : diff[SH_W-1:0];
    big_f   = x_big ? xf : yf;
    small_f = x_big ? yf : xf;
    // shifts past the operand width leave only its sign
    small_sh = small_f >>> shamt;
    sum      = {big_f[OPD_W-1], big_f} + {small_sh[OPD_W-1], small_sh};

    prod = WIDE_W'($signed(word_i.x_fraction)) * WIDE_W'($signed(word_i.y_fraction));

    is_mul = word_i.cmd inside {CMD_MUL, CMD_RSV};
    if (is_mul) begin
      word_o.exponent = xe + ye;
      word_o.fraction = prod >>> FRAC_BITS;
    end else begin
      word_o.exponent = x_big ? xe : ye;
      word_o.fraction = WIDE_W'(sum);
    end
  end

endmodule

`default_nettype wire

// ===== sv/pfanm_norm.sv =====
// ============================================================================
// pfanm_norm
// normalizes |fraction| into [one, 2*one) and saturates the exponent
// ============================================================================
`default_nettype none

module pfanm_norm #(
  parameter int unsigned FRAC_BITS = pfanm_pkg::FRAC_BITS_DEF
) (
  input  pfanm_pkg::mid_word_t word_i,
  output pfanm_pkg::out_word_t word_o
);
  import pfanm_pkg::*;

  localparam int unsigned ADJ_W = MID_EXP_W + 1;
  localparam logic [LEN_W-1:0] NORM_LEN = LEN_W'(FRAC_BITS + 1);
  // -(2*one): the only value a floored right shift can land on at 2*one
  localparam logic signed [WIDE_W-1:0] NEG_TWO =
    -(WIDE_W'(64'sd1) <<< (FRAC_BITS + 1));
  localparam logic signed [ADJ_W-1:0] EXP_HI = ADJ_W'(2**(EXP_W-1) - 1);
  localparam logic signed [ADJ_W-1:0] EXP_LO = -ADJ_W'(2**(EXP_W-1));

  logic [WIDE_W-1:0]        mag;
  logic [LEN_W-1:0]         len, rsh, lsh;
  logic signed [WIDE_W-1:0] f_r, f_n;
  logic signed [ADJ_W-1:0]  e_ext, e_adj;
  logic                     fix;

  always_comb begin
    mag   = word_i.fraction[WIDE_W-1] ? WIDE_W'(-word_i.fraction)
                                      : WIDE_W'(word_i.fraction);
    len   = bit_len(mag);
    rsh   = len - NORM_LEN;
    lsh   = NORM_LEN - len;
    e_ext = {word_i.exponent[MID_EXP_W-1], word_i.exponent};
    f_r   = word_i.fraction >>> rsh;
    fix   = (f_r == NEG_TWO);

    if (len > NORM_LEN) begin
      // shift down; negative values round toward minus infinity
      f_n   = fix ? (f_r >>> 1) : f_r;
      e_adj = e_ext + $signed({{(ADJ_W-LEN_W){1'b0}}, rsh})
                    + $signed({{(ADJ_W-1){1'b0}}, fix});
    end else begin
      f_n   = word_i.fraction <<< lsh;
      e_adj = e_ext - $signed({{(ADJ_W-LEN_W){1'b0}}, lsh});
    end

    word_o.z_fraction = f_n[FRAC_W-1:0];
    if (len == '0) begin
      word_o.z_exponent = '0;
    end else if (e_adj > EXP_HI) begin
      word_o.z_exponent = EXP_HI[EXP_W-1:0];
    end else if (e_adj < EXP_LO) begin
      word_o.z_exponent = EXP_LO[EXP_W-1:0];
    end else begin
      word_o.z_exponent = e_adj[EXP_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== sv/pseudo_float_add_mul_normalize.sv =====
// ============================================================================
// pseudo_float_add_mul_normalize
// pipelined add / subtract / multiply of (exponent, fraction) pseudo-floats
// ============================================================================
// usage:
//   in_i carries one operand word per handshake: cmd (add, subtract x minus
//   y, multiply; the spare code multiplies), and two exponent/fraction pairs.
//   out_o returns one normalized word per operand word, in order.
// timing:
//   three register stages: operand register, raw-result register after the
//   align/add or multiply, and the result register after normalization.
//   a word moves from the operand register to the raw-result register and
//   then to the result register, where out_o.valid shows it; one word enters
//   and one leaves every cycle while out_o.ready is high, since each stage is
//   a single combinational pass and all stages advance together.
// reset:
//   rst_ni clears all stage valid flags; the pipeline comes up empty and
//   in_i.ready is high.
// backpressure:
//   when out_o.ready is low the full stages hold; a stage still takes a new
//   word as long as some stage downstream has room, so bubbles are squeezed
//   out before in_i.ready drops.
// ============================================================================
`default_nettype none

module pseudo_float_add_mul_normalize #(
  parameter int unsigned FRAC_BITS = pfanm_pkg::FRAC_BITS_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  pfanm_in_if.sink       in_i,
  pfanm_out_if.source    out_o
);
  import pfanm_pkg::*;

  // stage valid flags
  logic v_op_q, v_op_d, v_mid_q, v_mid_d, v_res_q, v_res_d;
  // stage advance enables
  logic en_op, en_mid, en_res;

  in_word_t  op_q;
  mid_word_t mid_d, mid_q;
  out_word_t res_d, res_q;

  // a stage may load when empty or when its contents move on
  assign en_res = !v_res_q || out_o.ready;
  assign en_mid = !v_mid_q || en_res;
  assign en_op  = !v_op_q  || en_mid;

  assign in_i.ready = en_op;

  always_comb begin
    v_op_d  = en_op  ? in_i.valid : v_op_q;
    v_mid_d = en_mid ? v_op_q     : v_mid_q;
    v_res_d = en_res ? v_mid_q    : v_res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_op_q  <= 1'b0;
      v_mid_q <= 1'b0;
      v_res_q <= 1'b0;
    end else begin
      v_op_q  <= v_op_d;
      v_mid_q <= v_mid_d;
      v_res_q <= v_res_d;
    end
  end

  // operand register
  always_ff @(posedge clk_i) begin
    if (en_op && in_i.valid) begin
      op_q.cmd        <= in_i.cmd;
      op_q.x_exponent <= in_i.x_exponent;
      op_q.x_fraction <= in_i.x_fraction;
      op_q.y_exponent <= in_i.y_exponent;
      op_q.y_fraction <= in_i.y_fraction;
    end
  end

  // align and add, or multiply
  pfanm_arith #(
    .FRAC_BITS (FRAC_BITS)
  ) u_arith (
    .word_i (op_q),
    .word_o (mid_d)
  );

  always_ff @(posedge clk_i) begin
    if (en_mid && v_op_q) begin
      mid_q <= mid_d;
    end
  end

  // normalize and saturate
  pfanm_norm #(
    .FRAC_BITS (FRAC_BITS)
  ) u_norm (
    .word_i (mid_q),
    .word_o (res_d)
  );

  always_ff @(posedge clk_i) begin
    if (en_res && v_mid_q) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid      = v_res_q;
  assign out_o.z_exponent = res_q.z_exponent;
  assign out_o.z_fraction = res_q.z_fraction;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  localparam logic signed [FRAC_W:0] ONE_S = (FRAC_W+1)'(1) <<< FRAC_BITS;
  localparam logic signed [FRAC_W:0] TWO_S = (FRAC_W+1)'(1) <<< (FRAC_BITS + 1);

  logic signed [FRAC_W:0] z_ext;
  assign z_ext = {out_o.z_fraction[FRAC_W-1], out_o.z_fraction};

  // zero fraction always carries exponent zero
  a_zero_exp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && z_ext == '0) |-> out_o.z_exponent == '0)
    else $error("zero fraction with nonzero exponent");

  // nonzero results are normalized
  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && z_ext != '0) |->
      ((z_ext >= ONE_S && z_ext < TWO_S) || (z_ext <= -ONE_S && z_ext > -TWO_S)))
    else $error("result fraction out of normalized range");

  // an empty operand stage always takes a word
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_op_q |-> in_i.ready)
    else $error("input stalled with empty operand stage");

  // a word in the middle stage reaches the result stage when it has room
  a_mid_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_mid_q && en_res) |=> v_res_q)
    else $error("raw result lost between stages");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// ============================================================================
// testbench
// self-checking bench for the pseudo-float add / subtract / multiply unit
// ============================================================================
// operand words go in on a valid/ready channel and normalized words come back
// out. a scoreboard class predicts every result as each operand word is
// accepted and compares the returned words in order. a directed burst covers
// extreme fractions and exponents, every command, zero results, alignment
// past the width and exponent saturation. random words follow, with idle
// cycles on both sides, a quiet stretch, a long output stall and a drain
// pause.
// ============================================================================
`default_nettype none

import pfanm_pkg::*;

localparam longint EXP_TOP    = (longint'(1) << (EXP_W - 1)) - 1;
localparam longint EXP_BOTTOM = -(longint'(1) << (EXP_W - 1));

class pfanm_scoreboard;
  out_word_t   pending_results[$];
  int unsigned mismatches;
  int unsigned checked;
  int unsigned n_add;
  int unsigned n_sub;
  int unsigned n_mul;
  int unsigned n_zero;

  // align/add or multiply at full width, then normalize to one <= |f| < 2*one
  function out_word_t normalized_result(in_word_t w);
    longint      xe, ye, xf, yf, e, f, unit_l;
    longint      span;
    out_word_t   r;
    xe     = $signed(w.x_exponent);
    ye     = $signed(w.y_exponent);
    xf     = $signed(w.x_fraction);
    yf     = $signed(w.y_fraction);
    unit_l = longint'(1) << FRAC_BITS_DEF;
    if (w.cmd == CMD_MUL || w.cmd == CMD_RSV) begin
      e = xe + ye;
      f = (xf * yf) >>> FRAC_BITS_DEF;
    end else begin
      if (w.cmd == CMD_SUB) begin
        yf = -yf;
      end
      if (xe > ye) begin
        span = xe - ye;
        if (span > 63) span = 63;
        e = xe;
        f = xf + (yf >>> span);
      end else begin
        span = ye - xe;
        if (span > 63) span = 63;
        e = ye;
        f = yf + (xf >>> span);
      end
    end
    if (f == 0) begin
      e = 0;
    end else begin
      while ((f < 0 ? -f : f) >= 2 * unit_l) begin
        f = f >>> 1;
        e++;
      end
      while ((f < 0 ? -f : f) < unit_l) begin
        f = f * 2;
        e--;
      end
      if (e > EXP_TOP) e = EXP_TOP;
      if (e < EXP_BOTTOM) e = EXP_BOTTOM;
    end
    r.z_exponent = EXP_W'(e);
    r.z_fraction = FRAC_W'(f);
    return r;
  endfunction

  function void note_operand(in_word_t w);
    out_word_t r;
    r = normalized_result(w);
    pending_results.push_back(r);
    case (w.cmd)
      CMD_ADD: n_add++;
      CMD_SUB: n_sub++;
      default: n_mul++;
    endcase
    if (r.z_fraction == 0) n_zero++;
  endfunction

  function void check_result(out_word_t got);
    out_word_t want;
    if (pending_results.size() == 0) begin
      $error("result word with nothing expected: z_exponent %0d z_fraction %0d",
             got.z_exponent, got.z_fraction);
      mismatches++;
      return;
    end
    want = pending_results.pop_front();
    checked++;
    if (got.z_exponent !== want.z_exponent) begin
      $error("z_exponent: expected %0d, actual %0d", want.z_exponent, got.z_exponent);
      mismatches++;
    end
    if (got.z_fraction !== want.z_fraction) begin
      $error("z_fraction: expected %0d, actual %0d", want.z_fraction, got.z_fraction);
      mismatches++;
    end
  endfunction

  function int unsigned outstanding();
    return pending_results.size();
  endfunction
endclass

module testbench;

  localparam int unsigned RANDOM_WORDS   = 1500;
  localparam int unsigned IDLE_PCT       = 7;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES    = 10;
  localparam longint      UNIT           = longint'(1) << FRAC_BITS_DEF;
  localparam longint      FRAC_TOP       = 64'sd2147483647;
  localparam longint      FRAC_BOTTOM    = -64'sd2147483648;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  pfanm_in_if  in_if ();
  pfanm_out_if out_if ();

  pseudo_float_add_mul_normalize #(
    .FRAC_BITS (FRAC_BITS_DEF)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  pfanm_scoreboard sb = new();

  // knobs and counters of the sender, the receiver and the watchdog
  bit          allow_idle    = 1'b1;
  bit          hold_request  = 1'b0;
  int unsigned hold_left     = 0;
  int unsigned holds_done    = 0;
  int unsigned quiet_cycles  = 0;

  // clock: period 2
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // known values on every input before the first edge
  initial begin
    in_if.valid      = 1'b0;
    in_if.cmd        = CMD_ADD;
    in_if.x_exponent = '0;
    in_if.x_fraction = '0;
    in_if.y_exponent = '0;
    in_if.y_fraction = '0;
    out_if.ready     = 1'b0;
  end

  // build an operand word from plain numbers, truncated to the field widths
  function automatic in_word_t make_operand(cmd_e c, longint xe, longint xf,
                                            longint ye, longint yf);
    in_word_t w;
    w.cmd        = c;
    w.x_exponent = EXP_W'(xe);
    w.x_fraction = FRAC_W'(xf);
    w.y_exponent = EXP_W'(ye);
    w.y_fraction = FRAC_W'(yf);
    return w;
  endfunction

  // exponent near one of the saturation limits
  function automatic logic [EXP_W-1:0] rim_exponent();
    if ($urandom_range(1)) begin
      return EXP_W'(EXP_TOP - longint'($urandom_range(30)));
    end
    return EXP_W'(EXP_BOTTOM + longint'($urandom_range(30)));
  endfunction

  // fraction mix: raw bits, already normalized, tiny, or extreme
  function automatic logic [FRAC_W-1:0] random_fraction();
    longint      mag;
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 4) begin
      return FRAC_W'($urandom);
    end else if (pick < 8) begin
      mag = UNIT + longint'($urandom_range(32'(UNIT - 1)));
      return FRAC_W'($urandom_range(1) ? -mag : mag);
    end else if (pick < 9) begin
      return FRAC_W'(longint'($urandom_range(510)) - 255);
    end
    case ($urandom_range(4))
      0:       return FRAC_W'(FRAC_TOP);
      1:       return FRAC_W'(FRAC_BOTTOM);
      2:       return FRAC_W'(1);
      3:       return FRAC_W'(-1);
      default: return '0;
    endcase
  endfunction

  function automatic in_word_t random_operand();
    in_word_t    w;
    int unsigned pick;
    longint      base;
    w.cmd = CMD_W'($urandom_range(3));
    pick  = $urandom_range(9);
    if (pick < 2) begin
      // full exponent range, mostly huge alignment shifts
      w.x_exponent = EXP_W'($urandom);
      w.y_exponent = EXP_W'($urandom);
    end else if (pick < 4) begin
      // saturation territory
      w.x_exponent = rim_exponent();
      w.y_exponent = rim_exponent();
    end else begin
      // close exponents so both fractions really mix
      base         = longint'($urandom_range(200)) - 100;
      w.x_exponent = EXP_W'(base);
      w.y_exponent = EXP_W'(base + longint'($urandom_range(80)) - 40);
    end
    w.x_fraction = random_fraction();
    w.y_fraction = random_fraction();
    return w;
  endfunction

  // offer one word, with random idle cycles ahead of it, until accepted
  task automatic send_operand(input in_word_t w);
    while (allow_idle && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.cmd        <= w.cmd;
    in_if.x_exponent <= w.x_exponent;
    in_if.x_fraction <= w.x_fraction;
    in_if.y_exponent <= w.y_exponent;
    in_if.y_fraction <= w.y_fraction;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_operand(w);
  endtask

  task automatic wait_drained();
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  // receiver: check accepted words, then pick ready for the next edge
  always @(posedge clk_i) begin : result_sink
    out_word_t got;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got.z_exponent = out_if.z_exponent;
        got.z_fraction = out_if.z_fraction;
        sb.check_result(got);
      end
      if (hold_left > 0) begin
        // long stall so the pipeline fills and pushes back on the input
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        holds_done++;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= !(allow_idle && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // watchdog: too long with no word moving on either side ends the run
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles = 0;
    end else if (rst_ni) begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d cycles with no word accepted", quiet_cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin : stimulus
    in_word_t directed[$];

    // reset held from the start, released at an edge
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words
    directed.push_back(make_operand(CMD_ADD, 0, UNIT, 0, UNIT));
    // x minus x gives a zero result
    directed.push_back(make_operand(CMD_SUB, 7, 3 * UNIT / 2, 7, 3 * UNIT / 2));
    directed.push_back(make_operand(CMD_MUL, 100, 0, -5, FRAC_TOP));
    directed.push_back(make_operand(CMD_MUL, 0, FRAC_TOP, 0, FRAC_TOP));
    directed.push_back(make_operand(CMD_MUL, 0, FRAC_BOTTOM, 0, FRAC_BOTTOM));
    // negating the most negative fraction
    directed.push_back(make_operand(CMD_SUB, 3, FRAC_TOP, 3, FRAC_BOTTOM));
    directed.push_back(make_operand(CMD_ADD, -3, FRAC_BOTTOM, -3, FRAC_BOTTOM));
    // alignment far beyond the width keeps only the sign
    directed.push_back(make_operand(CMD_ADD, EXP_TOP, UNIT, EXP_BOTTOM, -UNIT));
    directed.push_back(make_operand(CMD_ADD, EXP_BOTTOM, FRAC_TOP, EXP_TOP, UNIT));
    directed.push_back(make_operand(CMD_SUB, 0, -UNIT, 63, UNIT));
    directed.push_back(make_operand(CMD_ADD, 64, UNIT, 0, FRAC_BOTTOM));
    // exponent saturation both ways
    directed.push_back(make_operand(CMD_MUL, EXP_TOP, FRAC_TOP, EXP_TOP, FRAC_TOP));
    directed.push_back(make_operand(CMD_MUL, EXP_BOTTOM, 1 << 20, EXP_BOTTOM, 3));
    directed.push_back(make_operand(CMD_ADD, EXP_TOP, FRAC_TOP, EXP_TOP, FRAC_TOP));
    directed.push_back(make_operand(CMD_SUB, EXP_BOTTOM, 1, EXP_BOTTOM, -1));
    // spare command decodes as multiply
    directed.push_back(make_operand(CMD_RSV, 2, 3 * UNIT / 2, -1, -UNIT));
    // tiny fractions normalize upward
    directed.push_back(make_operand(CMD_ADD, 0, 1, -200, 0));
    directed.push_back(make_operand(CMD_ADD, 0, -1, 0, 0));
    // truncating multiply rounds toward minus infinity
    directed.push_back(make_operand(CMD_MUL, 0, -1, 0, 1));
    directed.push_back(make_operand(CMD_MUL, 0, 1, 0, 1));
    directed.push_back(make_operand(CMD_SUB, 10, 5, 9, FRAC_TOP));
    foreach (directed[i]) begin
      send_operand(directed[i]);
    end

    // sender pauses until every expected word has come back
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    wait_drained();
    @(posedge clk_i);

    // random words
    for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
      // a long stretch with no idling on either side
      allow_idle = !(n >= 400 && n < 800);
      // receiver stalls while the sender keeps offering
      if (n == 900) hold_request = 1'b1;
      send_operand(random_operand());
    end
    in_if.valid <= 1'b0;

    // drain, then let the pipeline settle
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d words: %0d add, %0d subtract, %0d multiply, %0d zero results",
             sb.n_add + sb.n_sub + sb.n_mul, sb.n_add, sb.n_sub, sb.n_mul, sb.n_zero);
    $display("%0d results checked, %0d output stalls, %0d mismatches",
             sb.checked, holds_done, sb.mismatches);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
